@@ rtl/core/cterm_pkg.sv @@
// Shared types, constants and codes for the character-cell terminal engine.
`timescale 1ns / 1ps
package cterm_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLUMNS = 128;
    localparam int ATTR_BITS   = 16;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
    localparam int CELL_W      = 8 + ATTR_BITS;
    localparam int IQ_DEPTH    = 2;
    localparam int OQ_DEPTH    = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_BELL   = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [2:0] REG_ACTIVE_ROWS    = 3'd0;
    localparam logic [2:0] REG_ACTIVE_COLUMNS = 3'd1;
    localparam logic [2:0] REG_SCROLL_TOP     = 3'd2;
    localparam logic [2:0] REG_SCROLL_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_CURSOR_OVERLAY = 3'd4;
    localparam logic [2:0] REG_FILL_ATTRIBUTE = 3'd5;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_READ,
        CMD_CR,
        CMD_LF,
        CMD_BS,
        CMD_TAB,
        CMD_BELL,
        CMD_PRINT
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_PUT,
        ST_EMIT
    } engine_state_t;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_req;
        logic [4:0] row;
        logic [6:0] column;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  row_first;
        logic [4:0]  row_last;
        logic [6:0]  col_first;
        logic [6:0]  col_last;
        logic [7:0]  cell_char;
        logic [15:0] cell_attribute;
        logic        cursor_here;
        logic [4:0]  cursor_row_now;
        logic [6:0]  cursor_col_now;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  active_rows;
        logic [7:0]  active_columns;
        logic [4:0]  scroll_top;
        logic [4:0]  scroll_bottom;
        logic        cursor_overlay;
        logic [15:0] fill_attribute;
    } cfg_t;

    typedef struct packed {
        cmd_code_t  code;
        logic [7:0] byte_req;
        logic [4:0] row;
        logic [6:0] column;
    } cmd_t;

endpackage

@@ rtl/core/text_terminal_char_engine.sv @@
// Top level of the character-cell terminal engine.
// Input channel: drive request with push; a beat is taken when push is high and full is low.
// Write beats carry one byte; read beats name a row and column of the cell store.
// Result channel: the oldest result sits on result while empty is low; pop takes it.
// A printable byte yields an optional scroll result and then a cell result; BEL yields a
// bell result; a read yields one read result; CR, LF, BS, TAB and ESC yield nothing.
// Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is always high.
// Write registers only while the block is idle.
// A scroll moves the rows of the scroll region up by one through the single write port
// of the cell store, one cell a cycle, when bottom is below top, and then blanks the
// bottom row; when bottom and top are equal it only blanks that row.
// After reset the cell store is cleared to spaces, one cell a cycle, through all its cells;
// full stays high during that pass. When the receiver stalls, up to four results wait
// in the result queue and then the input queue of two commands fills and full rises.
`timescale 1ns / 1ps
module text_terminal_char_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  cterm_pkg::in_item_t  request,
    input  logic                 pop,
    output logic                 empty,
    output cterm_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import cterm_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    logic clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_rows    <= 6'd24;
            cfg_reg.active_columns <= 8'd80;
            cfg_reg.scroll_top     <= 5'd0;
            cfg_reg.scroll_bottom  <= 5'd23;
            cfg_reg.cursor_overlay <= 1'b1;
            cfg_reg.fill_attribute <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVE_ROWS:    cfg_reg.active_rows    <= cfg_data[5:0];
                REG_ACTIVE_COLUMNS: cfg_reg.active_columns <= cfg_data[7:0];
                REG_SCROLL_TOP:     cfg_reg.scroll_top     <= cfg_data[4:0];
                REG_SCROLL_BOTTOM:  cfg_reg.scroll_bottom  <= cfg_data[4:0];
                REG_CURSOR_OVERLAY: cfg_reg.cursor_overlay <= cfg_data[0];
                REG_FILL_ATTRIBUTE: cfg_reg.fill_attribute <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cterm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .clearing  (clearing),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    cterm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );
endmodule

@@ rtl/core/cterm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cterm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/cterm_front.sv @@
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
module cterm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cterm_pkg::in_item_t request,
    input  logic              clearing,
    output cterm_pkg::cmd_t   cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);
    import cterm_pkg::*;

    cmd_t       q_reg [IQ_DEPTH];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    cmd_t       classified;
    logic       accept;

    always_comb
    begin
        classified.byte_req = request.byte_req;
        classified.row      = request.row;
        classified.column   = request.column;
        if (request.op == OP_READ)
        begin
            classified.code = CMD_READ;
        end
        else
        begin
            case (request.byte_req)
                CH_CR:   classified.code = CMD_CR;
                CH_LF:   classified.code = CMD_LF;
                CH_BS:   classified.code = CMD_BS;
                CH_TAB:  classified.code = CMD_TAB;
                CH_BEL:  classified.code = CMD_BELL;
                CH_ESC:  classified.code = CMD_NOP;
                default: classified.code = CMD_PRINT;
            endcase
        end
    end

    assign full      = (count_reg == 2'(IQ_DEPTH)) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (accept)
        begin
            tail_next = ~tail_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            head_next = ~head_reg;
        end
        if (accept && !(cmd_pop && cmd_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && cmd_pop && cmd_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[tail_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end
endmodule

@@ rtl/core/cterm_back.sv @@
// Back end: cursor, cell store sequencer, scroll copy and result queue.
`timescale 1ns / 1ps
module cterm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cterm_pkg::cfg_t      cfg,
    input  cterm_pkg::cmd_t      cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    output logic                 clearing,
    input  logic                 pop,
    output logic                 empty,
    output cterm_pkg::out_item_t result
);
    import cterm_pkg::*;

    engine_state_t state_reg, state_next;
    logic [7:0]        crow_reg, crow_next;
    logic signed [8:0] ccol_reg, ccol_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [4:0]        r_cnt_reg, r_cnt_next;
    logic [6:0]        c_cnt_reg, c_cnt_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              pend_reg, pend_next;
    logic              scroll_reg, scroll_next;
    cmd_t              cmd_reg, cmd_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              here_reg, here_next;
    logic [4:0]        put_row_reg, put_row_next;
    logic [6:0]        put_col_reg, put_col_next;

    out_item_t  oq_reg [OQ_DEPTH];
    logic [1:0] oq_head_reg, oq_tail_reg;
    logic [2:0] oq_count_reg;
    logic       oq_push;
    out_item_t  oq_item;
    logic       oq_room;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CELL_W-1:0] wdata, rdata;

    logic [5:0] rows_used;
    logic [7:0] cols_used;
    logic [4:0] rows_m1, top, bot;
    logic [6:0] cols_m1;
    logic [4:0] cur_row_now;
    logic [6:0] cur_col_now;
    logic       wrap, need_scroll;
    logic [7:0] prow;
    logic signed [9:0] tab_col;
    logic [15:0] fill;

    cterm_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (cfg.active_rows == 6'd0)
        begin
            rows_used = 6'd1;
        end
        else if (cfg.active_rows > 6'(MAX_ROWS))
        begin
            rows_used = 6'(MAX_ROWS);
        end
        else
        begin
            rows_used = cfg.active_rows;
        end
        if (cfg.active_columns == 8'd0)
        begin
            cols_used = 8'd1;
        end
        else if (cfg.active_columns > 8'(MAX_COLUMNS))
        begin
            cols_used = 8'(MAX_COLUMNS);
        end
        else
        begin
            cols_used = cfg.active_columns;
        end
        rows_m1 = 5'(rows_used - 6'd1);
        cols_m1 = 7'(cols_used - 8'd1);
        top = (cfg.scroll_top > rows_m1) ? rows_m1 : cfg.scroll_top;
        bot = (cfg.scroll_bottom > rows_m1) ? rows_m1 : cfg.scroll_bottom;
        fill = cfg.fill_attribute;

        cur_row_now = (crow_reg > {3'd0, rows_m1}) ? rows_m1 : 5'(crow_reg);
        if (ccol_reg < 9'sd0)
        begin
            cur_col_now = 7'd0;
        end
        else if (ccol_reg > $signed({2'b00, cols_m1}))
        begin
            cur_col_now = cols_m1;
        end
        else
        begin
            cur_col_now = 7'(ccol_reg);
        end

        wrap = ccol_reg >= $signed({1'b0, cols_used});
        if (wrap)
        begin
            prow = (crow_reg == 8'd255) ? 8'd255 : crow_reg + 8'd1;
        end
        else
        begin
            prow = crow_reg;
        end
        need_scroll = prow > {3'd0, bot};
        tab_col = ({ccol_reg[8], ccol_reg} & ~10'sd7) + 10'sd8;
    end

    assign oq_room  = oq_count_reg <= 3'(OQ_DEPTH - 2);
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next   = state_reg;
        crow_next    = crow_reg;
        ccol_next    = ccol_reg;
        clr_next     = clr_reg;
        r_cnt_next   = r_cnt_reg;
        c_cnt_next   = c_cnt_reg;
        dst_next     = dst_reg;
        pend_next    = pend_reg;
        scroll_next  = scroll_reg;
        cmd_next     = cmd_reg;
        rd_ok_next   = rd_ok_reg;
        here_next    = here_reg;
        put_row_next = put_row_reg;
        put_col_next = put_col_reg;
        cmd_pop      = 1'b0;
        we           = 1'b0;
        waddr        = clr_reg;
        wdata        = {CH_SPACE, 16'd0};
        raddr        = {r_cnt_reg + 5'd1, c_cnt_reg};
        oq_push      = 1'b0;
        oq_item      = '0;
        oq_item.cursor_row_now = cur_row_now;
        oq_item.cursor_col_now = cur_col_now;
        oq_item.last           = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && oq_room)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.code)
                        CMD_READ:
                        begin
                            raddr      = {cmd.row, cmd.column};
                            rd_ok_next = ({1'b0, cmd.row} < rows_used)
                                      && ({1'b0, cmd.column} < cols_used);
                            here_next  = rd_ok_next && cfg.cursor_overlay
                                      && (crow_reg == {3'd0, cmd.row})
                                      && ((ccol_reg == $signed({2'b00, cmd.column}))
                                       || ((cmd.column == cols_m1)
                                        && (ccol_reg == $signed({1'b0, cols_used}))));
                            state_next = ST_READ;
                        end
                        CMD_CR:
                        begin
                            ccol_next = 9'sd0;
                        end
                        CMD_LF:
                        begin
                            if (crow_reg != 8'd255)
                            begin
                                crow_next = crow_reg + 8'd1;
                            end
                        end
                        CMD_BS:
                        begin
                            if (ccol_reg != -9'sd256)
                            begin
                                ccol_next = ccol_reg - 9'sd1;
                            end
                        end
                        CMD_TAB:
                        begin
                            ccol_next = (tab_col > 10'sd255) ? 9'sd255 : 9'(tab_col);
                        end
                        CMD_BELL:
                        begin
                            oq_push      = 1'b1;
                            oq_item.kind = KIND_BELL;
                        end
                        CMD_PRINT:
                        begin
                            ccol_next   = wrap ? 9'sd0 : ccol_reg;
                            crow_next   = need_scroll ? prow - 8'd1 : prow;
                            scroll_next = need_scroll && (top <= bot);
                            r_cnt_next  = top;
                            c_cnt_next  = 7'd0;
                            pend_next   = 1'b0;
                            if (!scroll_next)
                            begin
                                state_next = ST_PUT;
                            end
                            else if (top == bot)
                            begin
                                state_next = ST_BLANK;
                            end
                            else
                            begin
                                state_next = ST_COPY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                oq_push                = 1'b1;
                oq_item.kind           = KIND_READ;
                oq_item.row_first      = cmd_reg.row;
                oq_item.row_last       = cmd_reg.row;
                oq_item.col_first      = cmd_reg.column;
                oq_item.col_last       = cmd_reg.column;
                oq_item.cell_char      = rd_ok_reg ? rdata[CELL_W-1 -: 8] : CH_SPACE;
                oq_item.cell_attribute = rd_ok_reg ? rdata[ATTR_BITS-1:0] : 16'd0;
                oq_item.cursor_here    = here_reg;
                state_next             = ST_IDLE;
            end
            ST_COPY:
            begin
                raddr     = {r_cnt_reg + 5'd1, c_cnt_reg};
                we        = pend_reg;
                waddr     = dst_reg;
                wdata     = rdata;
                pend_next = 1'b1;
                dst_next  = {r_cnt_reg, c_cnt_reg};
                if (c_cnt_reg == cols_m1)
                begin
                    c_cnt_next = 7'd0;
                    r_cnt_next = r_cnt_reg + 5'd1;
                    if (r_cnt_reg + 5'd1 == bot)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    c_cnt_next = c_cnt_reg + 7'd1;
                end
            end
            ST_DRAIN:
            begin
                we         = 1'b1;
                waddr      = dst_reg;
                wdata      = rdata;
                pend_next  = 1'b0;
                c_cnt_next = 7'd0;
                state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                we    = 1'b1;
                waddr = {bot, c_cnt_reg};
                wdata = {CH_SPACE, fill};
                if (c_cnt_reg == cols_m1)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    c_cnt_next = c_cnt_reg + 7'd1;
                end
            end
            ST_PUT:
            begin
                we           = 1'b1;
                waddr        = {cur_row_now, cur_col_now};
                wdata        = {cmd_reg.byte_req, fill};
                put_row_next = cur_row_now;
                put_col_next = cur_col_now;
                if (ccol_reg != 9'sd255)
                begin
                    ccol_next = ccol_reg + 9'sd1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                oq_push = 1'b1;
                if (scroll_reg)
                begin
                    oq_item.kind      = KIND_SCROLL;
                    oq_item.row_first = top;
                    oq_item.row_last  = bot;
                    oq_item.col_last  = cols_m1;
                    oq_item.last      = 1'b0;
                    scroll_next       = 1'b0;
                end
                else
                begin
                    oq_item.kind           = KIND_CELL;
                    oq_item.row_first      = put_row_reg;
                    oq_item.row_last       = put_row_reg;
                    oq_item.col_first      = put_col_reg;
                    oq_item.col_last       = put_col_reg;
                    oq_item.cell_char      = cmd_reg.byte_req;
                    oq_item.cell_attribute = fill;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign empty  = (oq_count_reg == 3'd0);
    assign result = oq_reg[oq_head_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_tail_reg] <= oq_item;
        end
        r_cnt_reg   <= r_cnt_next;
        c_cnt_reg   <= c_cnt_next;
        dst_reg     <= dst_next;
        cmd_reg     <= cmd_next;
        rd_ok_reg   <= rd_ok_next;
        here_reg    <= here_next;
        put_row_reg <= put_row_next;
        put_col_reg <= put_col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            crow_reg     <= 8'd0;
            ccol_reg     <= 9'sd0;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            scroll_reg   <= 1'b0;
            oq_head_reg  <= 2'd0;
            oq_tail_reg  <= 2'd0;
            oq_count_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            crow_reg    <= crow_next;
            ccol_reg    <= ccol_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            scroll_reg  <= scroll_next;
            if (oq_push)
            begin
                oq_tail_reg <= oq_tail_reg + 2'd1;
            end
            if (pop && !empty)
            begin
                oq_head_reg <= oq_head_reg + 2'd1;
            end
            if (oq_push && !(pop && !empty))
            begin
                oq_count_reg <= oq_count_reg + 3'd1;
            end
            else if (!oq_push && pop && !empty)
            begin
                oq_count_reg <= oq_count_reg - 3'd1;
            end
        end
    end
endmodule

@@ rtl/core/cterm_checker.sv @@
// Port-level checker for the terminal engine and its bind statement.
`timescale 1ns / 1ps
module cterm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input cterm_pkg::out_item_t result,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);
    import cterm_pkg::*;

    // A scroll result is never marked last, since the cell result of the same byte follows it.
    a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_SCROLL) |-> !result.last)
        else $error("scroll beat marked as last");

    a_here_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_READ) |-> !result.cursor_here)
        else $error("cursor flag on a non-read beat");

    a_bell_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_BELL) |->
        (result.row_first == 5'd0 && result.col_last == 7'd0
         && result.cell_char == 8'd0 && result.last))
        else $error("bell beat carries position data");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");
endmodule

bind text_terminal_char_engine cterm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ bench/text_terminal_char_engine_test.sv @@
// Self-checking bench for the terminal engine: directed and random byte and read beats against a scoreboard.
`timescale 1ns / 1ps
module text_terminal_char_engine_test;
    import cterm_pkg::*;

    class screen_scoreboard;
        logic [7:0]  chars [CELLS];
        logic [15:0] attrs [CELLS];
        int          crow;
        int          ccol;
        logic [5:0]  rows_reg;
        logic [7:0]  cols_reg;
        logic [4:0]  top_reg;
        logic [4:0]  bot_reg;
        logic        overlay;
        logic [15:0] fill;
        out_item_t   awaited_q [$];
        out_item_t   batch [$];
        int          mismatches;
        int          results_seen;
        int          scrolls_seen;
        int          flagged_reads;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                chars[i] = CH_SPACE;
                attrs[i] = '0;
            end
            crow = 0;
            ccol = 0;
            rows_reg = 6'd24;
            cols_reg = 8'd80;
            top_reg = 5'd0;
            bot_reg = 5'd23;
            overlay = 1'b1;
            fill = '0;
            mismatches = 0;
            results_seen = 0;
            scrolls_seen = 0;
            flagged_reads = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_ACTIVE_ROWS:    rows_reg = data[5:0];
                REG_ACTIVE_COLUMNS: cols_reg = data[7:0];
                REG_SCROLL_TOP:     top_reg = data[4:0];
                REG_SCROLL_BOTTOM:  bot_reg = data[4:0];
                REG_CURSOR_OVERLAY: overlay = data[0];
                REG_FILL_ATTRIBUTE: fill = data;
                default: ;
            endcase
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int rows_in_use();
            return clamp(int'(rows_reg), 1, MAX_ROWS);
        endfunction

        function int cols_in_use();
            return clamp(int'(cols_reg), 1, MAX_COLUMNS);
        endfunction

        function void add(logic [1:0] kind, int r0, int r1, int c0, int c1,
                          logic [7:0] ch, logic [15:0] at, logic here);
            out_item_t o;
            o = '0;
            o.kind = kind;
            o.row_first = r0[4:0];
            o.row_last = r1[4:0];
            o.col_first = c0[6:0];
            o.col_last = c1[6:0];
            o.cell_char = ch;
            o.cell_attribute = at;
            o.cursor_here = here;
            batch.push_back(o);
        endfunction

        function void print_byte(logic [7:0] b);
            int rows;
            int cols;
            int top;
            int bot;
            int r;
            int c;
            int d;
            rows = rows_in_use();
            cols = cols_in_use();
            top = clamp(int'(top_reg), 0, rows - 1);
            bot = clamp(int'(bot_reg), 0, rows - 1);
            if (ccol >= cols)
            begin
                ccol = 0;
                if (crow < 255)
                    crow++;
            end
            if (crow > bot)
            begin
                if (top <= bot)
                begin
                    for (r = top; r < bot; r++)
                        for (c = 0; c < cols; c++)
                        begin
                            d = r * MAX_COLUMNS + c;
                            chars[d] = chars[d + MAX_COLUMNS];
                            attrs[d] = attrs[d + MAX_COLUMNS];
                        end
                    for (c = 0; c < cols; c++)
                    begin
                        chars[bot * MAX_COLUMNS + c] = CH_SPACE;
                        attrs[bot * MAX_COLUMNS + c] = fill;
                    end
                    add(KIND_SCROLL, top, bot, 0, cols - 1, '0, '0, 1'b0);
                    scrolls_seen++;
                end
                crow--;
            end
            r = clamp(crow, 0, rows - 1);
            c = clamp(ccol, 0, cols - 1);
            chars[r * MAX_COLUMNS + c] = b;
            attrs[r * MAX_COLUMNS + c] = fill;
            add(KIND_CELL, r, r, c, c, b, fill, 1'b0);
            if (ccol < 255)
                ccol++;
        endfunction

        function void note_input(in_item_t it);
            int rows;
            int cols;
            int r;
            int c;
            logic [7:0]  ch;
            logic [15:0] at;
            logic        here;
            rows = rows_in_use();
            cols = cols_in_use();
            batch.delete();
            if (it.op == OP_READ)
            begin
                r = int'(it.row);
                c = int'(it.column);
                ch = CH_SPACE;
                at = '0;
                here = 1'b0;
                if (r < rows && c < cols)
                begin
                    ch = chars[r * MAX_COLUMNS + c];
                    at = attrs[r * MAX_COLUMNS + c];
                    here = overlay && crow == r &&
                           (ccol == c || (c == cols - 1 && ccol == cols));
                end
                if (here)
                    flagged_reads++;
                add(KIND_READ, r, r, c, c, ch, at, here);
            end
            else
            begin
                case (it.byte_req)
                    CH_CR:  ccol = 0;
                    CH_LF:  if (crow < 255) crow++;
                    CH_BS:  if (ccol > -256) ccol--;
                    CH_TAB:
                    begin
                        ccol = (ccol & ~7) + 8;
                        if (ccol > 255)
                            ccol = 255;
                    end
                    CH_BEL: add(KIND_BELL, 0, 0, 0, 0, '0, '0, 1'b0);
                    CH_ESC: ;
                    default: print_byte(it.byte_req);
                endcase
            end
            foreach (batch[k])
            begin
                r = clamp(crow, 0, rows - 1);
                c = clamp(ccol, 0, cols - 1);
                batch[k].cursor_row_now = r[4:0];
                batch[k].cursor_col_now = c[6:0];
                batch[k].last = (k == batch.size() - 1);
                awaited_q.push_back(batch[k]);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (awaited_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            want = awaited_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    request = '0;
    logic        pop = 1'b0;
    logic        empty;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int send_idle = 21;
    int recv_idle = 55;
    int beats_sent = 0;
    screen_scoreboard sb = new();

    text_terminal_char_engine dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .request(request),
        .pop(pop), .empty(empty), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                sb.check_result(result);
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (full);
        sb.note_input(it);
        beats_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        in_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.byte_req = b;
        it.row = 5'($urandom);
        it.column = 7'($urandom);
        send(it);
    endtask

    task automatic send_read(logic [4:0] r, logic [6:0] c);
        in_item_t it;
        it = '0;
        it.op = OP_READ;
        it.byte_req = 8'($urandom);
        it.row = r;
        it.column = c;
        send(it);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.awaited_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic screen_setup(int rows, int cols, int top, int bot, int ovl, int attr);
        settle();
        write_reg(REG_ACTIVE_ROWS, 16'(rows));
        write_reg(REG_ACTIVE_COLUMNS, 16'(cols));
        write_reg(REG_SCROLL_TOP, 16'(top));
        write_reg(REG_SCROLL_BOTTOM, 16'(bot));
        write_reg(REG_CURSOR_OVERLAY, 16'(ovl));
        write_reg(REG_FILL_ATTRIBUTE, 16'(attr));
    endtask

    task automatic random_items(int count);
        int pick;
        int n;
        logic [7:0] ctl;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 1)
            begin
                case ($urandom_range(3))
                    0: ctl = CH_BS;
                    1: ctl = CH_LF;
                    2: ctl = CH_TAB;
                    default: ctl = CH_CR;
                endcase
                n = (ctl == CH_TAB) ? 40 : 260;
                repeat (n) send_byte(ctl);
            end
            else if (pick < 45)
                send_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126)));
            else if (pick < 58)
            begin
                case ($urandom_range(5))
                    0: ctl = CH_CR;
                    1: ctl = CH_LF;
                    2: ctl = CH_BS;
                    3: ctl = CH_TAB;
                    4: ctl = CH_BEL;
                    default: ctl = CH_ESC;
                endcase
                send_byte(ctl);
            end
            else if (pick < 78)
                send_read(5'(sb.crow + $urandom_range(2) - 1),
                          7'(sb.ccol + $urandom_range(2) - 1));
            else
                send_read(5'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("[text_terminal_char_engine] ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_read(5'd0, 7'd0);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BEL);
        send_read(5'd0, 7'd2);
        send_read(5'd0, 7'd3);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(CH_ESC);
        send_byte(CH_CR);
        send_read(5'd1, 7'd0);
        send_read(5'd31, 7'd127);
        send_read(5'd23, 7'd79);
        screen_setup(2, 8, 0, 1, 1, 16'hFFFF);
        repeat (8) send_byte(8'h5A);
        send_read(5'd0, 7'd7);
        send_byte(8'h42);
        send_read(5'd1, 7'd0);
        send_read(5'd0, 7'd0);

        for (int phase = 0; phase < 9; phase++)
        begin
            if (phase == 3)
            begin
                send_idle = 55;
                recv_idle = 21;
            end
            else if (phase == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (phase % 9)
                0: screen_setup(24, 80, 0, 23, 1, 16'h0000);
                1: screen_setup(8, 16, 2, 5, 1, 16'hA5C3);
                2: screen_setup(0, 0, 31, 31, 0, 16'hFFFF);
                3: screen_setup(6, 20, 4, 2, 1, 16'h1234);
                4: screen_setup(63, 255, 0, 31, 1, 16'h8001);
                5: screen_setup(32, 128, 31, 0, 1, 16'h00FF);
                6: screen_setup(4, 9, 0, 3, 0, 16'h5555);
                7: screen_setup(3, 8, 1, 31, 1, 16'hFFFF);
                default: screen_setup(12, 40, 3, 9, 1, 16'h0F0F);
            endcase
            random_items((phase == 4) ? 20 : 40);
        end

        settle();
        repeat (100) @(posedge clk);
        $display("Sent %0d beats over nine screen settings; %0d results checked.",
                 beats_sent, sb.results_seen);
        $display("Scrolls predicted: %0d, cursor-flagged reads: %0d, mismatches: %0d.",
                 sb.scrolls_seen, sb.flagged_reads, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_q.size() == 0)
            $display("[text_terminal_char_engine] OK");
        else
            $display("[text_terminal_char_engine] ERROR");
        $finish;
    end
endmodule
